/* rtl/mmss_pkg.sv */
package mmss_pkg;
	localparam int DEF_MAX_STALLS = 1024;
	localparam int DEF_POS_BITS   = 30;
	localparam int FIELD_W        = 30;
	localparam int CFG_W          = 11;
	localparam logic [CFG_W-1:0] COW_RESET = 11'd2;
	localparam int QUEUE_DEPTH    = 4;
endpackage

/* rtl/mmss_queue.sv */
module mmss_queue import mmss_pkg::*; #(
	parameter int W = DEF_POS_BITS + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         q_full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         q_empty
);
	localparam int QAW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]   slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	assign q_full  = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !q_full) slot_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !q_full) wp_q <= wp_q + 1'b1;
			if (rd_en && !q_empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr_en && !q_full) - (QAW+1)'(rd_en && !q_empty);
		end
	end
endmodule

/* rtl/mmss_front.sv */
module mmss_front import mmss_pkg::*; #(
	parameter int POS_BITS = DEF_POS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FIELD_W-1:0]  position,
	input  logic                last,
	input  logic                push,
	output logic                full,
	output logic                q_wr,
	output logic [POS_BITS:0]   q_data,
	input  logic                q_full
);
	logic                valid_s1;
	logic [POS_BITS-1:0] pos_s1;
	logic                last_s1;
	logic [31:0]         pos_ext;

	assign pos_ext = {{(32-FIELD_W){1'b0}}, position};
	assign full    = valid_s1 && q_full;
	assign q_wr    = valid_s1;
	assign q_data  = {last_s1, pos_s1};

	always_ff @(posedge clk) begin
		if (push && !full) begin
			pos_s1  <= pos_ext[POS_BITS-1:0];
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (push && !full) valid_s1 <= 1'b1;
		else if (!q_full) valid_s1 <= 1'b0;
	end
endmodule

/* rtl/mmss_back.sv */
module mmss_back import mmss_pkg::*; #(
	parameter int MAX_STALLS = DEF_MAX_STALLS,
	parameter int POS_BITS   = DEF_POS_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CFG_W-1:0]   cow_count,
	input  logic [POS_BITS:0]  q_data,
	input  logic               q_empty,
	output logic               q_rd,
	output logic [FIELD_W-1:0] best_spacing,
	output logic               too_many,
	output logic               empty,
	input  logic               pop
);
	localparam int AW = $clog2(MAX_STALLS);
	localparam int CW = $clog2(MAX_STALLS + 1);
	localparam int LW = POS_BITS + 1;
	localparam int PW = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [3:0] {
		LD, INS_RD, INS_CMP, SR_A, SR_B, SR_C, BS, SC_PREV, SCAN, SC_END, DONE
	} state_t;

	state_t              state_q;
	logic [POS_BITS-1:0] mem [MAX_STALLS];
	logic [POS_BITS-1:0] rdata_q;
	logic [AW-1:0]       raddr, waddr;
	logic [POS_BITS-1:0] wdata;
	logic                we;

	logic [CW-1:0]       cnt_q, iss_q, picked_q;
	logic [AW-1:0]       j_q;
	logic [POS_BITS-1:0] v_q, prev_q, first_q;
	logic                last_q, ovf_q, rv_q;
	logic [LW-1:0]       lo_q, hi_q, mid_q, best_q;
	logic [LW:0]         mid_sum;
	logic [POS_BITS-1:0] diff;
	logic [CW-1:0]       nm1;
	logic                res_v_q, res_ovf_q;
	logic [LW-1:0]       res_best_q;
	logic [31:0]         res_ext;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign diff    = rdata_q - prev_q;
	assign nm1     = cnt_q - 1'b1;
	assign q_rd    = (state_q == LD) && !q_empty;

	assign res_ext      = 32'(res_best_q);
	assign best_spacing = res_ext[FIELD_W-1:0];
	assign too_many     = res_ovf_q;
	assign empty        = !res_v_q;

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = j_q;
		wdata = v_q;
		unique case (state_q)
			INS_RD:  raddr = j_q - 1'b1;
			INS_CMP: begin
				we = 1'b1;
				if (j_q != '0 && rdata_q > v_q) wdata = rdata_q;
			end
			SR_B:    raddr = nm1[AW-1:0];
			SC_PREV: raddr = AW'(1);
			SCAN:    raddr = iss_q[AW-1:0];
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= LD;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b0;
			rv_q       <= 1'b0;
			res_v_q    <= 1'b0;
			j_q        <= '0;
			iss_q      <= '0;
			picked_q   <= '0;
			v_q        <= '0;
			prev_q     <= '0;
			first_q    <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			best_q     <= '0;
			res_best_q <= '0;
			res_ovf_q  <= 1'b0;
		end else begin
			if (pop && res_v_q) res_v_q <= 1'b0;
			unique case (state_q)
				LD: if (!q_empty) begin
					last_q <= q_data[POS_BITS];
					if (cnt_q == CW'(MAX_STALLS)) begin
						ovf_q <= 1'b1;
						if (q_data[POS_BITS]) state_q <= SR_A;
					end else begin
						v_q     <= q_data[POS_BITS-1:0];
						j_q     <= cnt_q[AW-1:0];
						cnt_q   <= cnt_q + 1'b1;
						state_q <= INS_RD;
					end
				end
				INS_RD: state_q <= INS_CMP;
				INS_CMP: begin
					// shift larger entry up, or drop the new value in its slot
					if (j_q != '0 && rdata_q > v_q) begin
						j_q     <= j_q - 1'b1;
						state_q <= INS_RD;
					end else begin
						state_q <= last_q ? SR_A : LD;
					end
				end
				SR_A: state_q <= SR_B;
				SR_B: begin
					first_q <= rdata_q;
					state_q <= SR_C;
				end
				SR_C: begin
					hi_q    <= {1'b0, rdata_q - first_q};
					lo_q    <= LW'(1);
					best_q  <= '0;
					state_q <= BS;
				end
				BS: begin
					if (lo_q <= hi_q) begin
						mid_q   <= mid_sum[LW:1];
						state_q <= SC_PREV;
					end else begin
						state_q <= DONE;
					end
				end
				SC_PREV: begin
					prev_q   <= rdata_q;
					picked_q <= CW'(1);
					iss_q    <= CW'(2);
					rv_q     <= (cnt_q > CW'(1));
					state_q  <= (cnt_q > CW'(1)) ? SCAN : SC_END;
				end
				SCAN: begin
					if (rv_q) begin
						if ({1'b0, diff} >= mid_q) begin
							picked_q <= picked_q + 1'b1;
							prev_q   <= rdata_q;
						end
						rv_q  <= (iss_q < cnt_q);
						iss_q <= iss_q + 1'b1;
					end else begin
						state_q <= SC_END;
					end
				end
				SC_END: begin
					if (PW'(picked_q) >= PW'(cow_count)) begin
						best_q <= mid_q;
						lo_q   <= mid_q + 1'b1;
					end else begin
						hi_q   <= mid_q - 1'b1;
					end
					state_q <= BS;
				end
				DONE: if (!res_v_q) begin
					res_v_q    <= 1'b1;
					res_best_q <= best_q;
					res_ovf_q  <= ovf_q;
					cnt_q      <= '0;
					ovf_q      <= 1'b0;
					state_q    <= LD;
				end
				default: state_q <= LD;
			endcase
		end
	end
endmodule

/* rtl/max_min_spacing_search.sv */
// Each position passes the front register and the queue to enter the store, and moves past every
// larger entry on insertion into sorted order. When the last position of a set lands,
// a binary search over the spacing runs about log2(max - min) greedy scans, each reading
// the store at one entry per cycle. Insertion moves past no entry when the positions
// arrive in ascending order.
// The result waits in an output register until popped; the next set may load meanwhile.
module max_min_spacing_search import mmss_pkg::*; #(
	parameter int MAX_STALLS = DEF_MAX_STALLS,
	parameter int POS_BITS   = DEF_POS_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic [FIELD_W-1:0] position,
	input  logic               last,
	input  logic               push,
	output logic               full,
	output logic [FIELD_W-1:0] best_spacing,
	output logic               too_many,
	output logic               empty,
	input  logic               pop
);
	logic [CFG_W-1:0]  cow_count_q;
	logic              f_wr, q_full, q_empty, q_rd;
	logic [POS_BITS:0] f_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cow_count_q <= COW_RESET;
		else if (cfg_we) cow_count_q <= cfg_wdata;
	end

	mmss_front #(.POS_BITS(POS_BITS)) u_front (
		.clk, .arst_n, .position, .last, .push, .full,
		.q_wr(f_wr), .q_data(f_data), .q_full
	);

	mmss_queue #(.W(POS_BITS + 1)) u_queue (
		.clk, .arst_n, .wr_en(f_wr), .wr_data(f_data), .q_full,
		.rd_en(q_rd), .rd_data(q_data), .q_empty
	);

	mmss_back #(.MAX_STALLS(MAX_STALLS), .POS_BITS(POS_BITS)) u_back (
		.clk, .arst_n, .cow_count(cow_count_q), .q_data, .q_empty, .q_rd,
		.best_spacing, .too_many, .empty, .pop
	);
endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import mmss_pkg::*;

	localparam int STORE_DEPTH = DEF_MAX_STALLS;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam logic [FIELD_W-1:0] POS_MAX = {FIELD_W{1'b1}};

	typedef struct packed {
		logic [FIELD_W-1:0] spacing;
		logic               dropped;
	} spacing_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	logic [FIELD_W-1:0] position;
	logic               last;
	logic               push;
	logic               full;
	logic [FIELD_W-1:0] best_spacing;
	logic               too_many;
	logic               empty;
	logic               pop;

	max_min_spacing_search dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.position(position), .last(last), .push(push), .full(full),
		.best_spacing(best_spacing), .too_many(too_many), .empty(empty), .pop(pop)
	);

	// predictor state
	logic [FIELD_W-1:0] set_positions[$];
	logic               set_dropped;
	logic [CFG_W-1:0]   cow_cfg;
	spacing_result_t    pending_spacings[$];
	int                 error_count;
	int                 items_sent;
	bit                 no_idle;
	longint             cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit greedy_fits(longint d);
		longint prev;
		int     picked;
		picked = 1;
		prev = set_positions[0];
		for (int i = 1; i < set_positions.size(); i++) begin
			if (longint'(set_positions[i]) - prev >= d) begin
				picked++;
				prev = set_positions[i];
			end
		end
		return picked >= int'(cow_cfg);
	endfunction

	function automatic logic [FIELD_W-1:0] search_best_spacing();
		longint lo, hi, mid, best;
		best = 0;
		if (set_positions.size() == 0) return '0;
		set_positions.sort();
		lo = 1;
		hi = longint'(set_positions[$]) - longint'(set_positions[0]);
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (greedy_fits(mid)) begin
				best = mid;
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return FIELD_W'(best);
	endfunction

	task automatic send_position(input logic [FIELD_W-1:0] pos, input logic is_last);
		int gap;
		spacing_result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		position <= pos;
		last <= is_last;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		if (set_positions.size() < STORE_DEPTH) set_positions.push_back(pos);
		else set_dropped = 1'b1;
		if (is_last) begin
			res.spacing = search_best_spacing();
			res.dropped = set_dropped;
			pending_spacings.push_back(res);
			set_positions.delete();
			set_dropped = 1'b0;
		end
	endtask

	task automatic send_set(input logic [FIELD_W-1:0] vals[$]);
		foreach (vals[i]) send_position(vals[i], i == vals.size() - 1);
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_spacings.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cow_count(input logic [CFG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cow_cfg = v;
	endtask

	task automatic test_reset_count();
		send_set('{30'd0, 30'd10, 30'd4});
		send_set('{30'd0, POS_MAX});
		send_set('{30'd7});
		send_set('{POS_MAX});
		send_set('{30'd5, 30'd5, 30'd5});
	endtask

	task automatic test_count_extremes();
		write_cow_count(11'd1);
		send_set('{30'd100, 30'd3, 30'd50});
		send_set('{POS_MAX, 30'd0});
		write_cow_count(11'd0);
		send_set('{30'd9, 30'd1, 30'd4});
		write_cow_count(11'd3);
		send_set('{30'd0, 30'd1, 30'd2, 30'd8, 30'd9});
		send_set('{30'd1, 30'd2});
		write_cow_count(11'd2047);
		send_set('{30'd0, 30'd5, 30'd10});
	endtask

	// ascending order keeps the insertion cheap for a full store
	task automatic test_store_overflow();
		write_cow_count(11'd1024);
		for (int i = 0; i < STORE_DEPTH + 6; i++) send_position(FIELD_W'(i * 3), 1'b0);
		send_position(FIELD_W'(5000), 1'b1);
		write_cow_count(11'd2);
		send_set('{30'd1, 30'd20});
	endtask

	task automatic test_random_sets();
		logic [FIELD_W-1:0] vals[$];
		int n;
		int sets;
		logic [FIELD_W-1:0] base;
		int span;
		sets = 0;
		while (items_sent < 1350) begin
			if (sets % 30 == 0) begin
				case ($urandom_range(0, 5))
					0: write_cow_count(11'd1);
					1: write_cow_count(CFG_W'($urandom_range(0, 2047)));
					default: write_cow_count(CFG_W'($urandom_range(2, 6)));
				endcase
				no_idle = ($urandom_range(0, 3) == 0);
			end
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			vals.delete();
			if ($urandom_range(0, 1)) begin
				base = FIELD_W'($urandom_range(0, 32'h3FFF_0000));
				span = $urandom_range(1, 200);
				for (int i = 0; i < n; i++) vals.push_back(base + FIELD_W'($urandom_range(0, span)));
			end else begin
				for (int i = 0; i < n; i++) vals.push_back(FIELD_W'($urandom()));
			end
			send_set(vals);
			sets++;
		end
	endtask

	// result side: random pop stalls, checked against oldest prediction
	int pop_wait;
	always @(posedge clk) begin
		spacing_result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_spacings.size() == 0) begin
					$error("unexpected result best_spacing=%0d too_many=%0d", best_spacing, too_many);
					error_count++;
				end else begin
					want = pending_spacings.pop_front();
					if (best_spacing !== want.spacing) begin
						$error("best_spacing expected %0d actual %0d", want.spacing, best_spacing);
						error_count++;
					end
					if (too_many !== want.dropped) begin
						$error("too_many expected %0d actual %0d", want.dropped, too_many);
						error_count++;
					end
				end
			end
			if (pop_wait > 0) begin
				pop_wait <= pop_wait - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				pop_wait <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("max_min_spacing_search test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		position = '0;
		last = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		pop_wait = 0;
		cycle_count = 0;
		error_count = 0;
		items_sent = 0;
		no_idle = 1'b0;
		set_dropped = 1'b0;
		cow_cfg = COW_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_count_extremes();
		test_store_overflow();
		test_random_sets();
		drain();
		if (error_count == 0) begin
			$display("max_min_spacing_search test passed");
		end else begin
			$display("max_min_spacing_search test failed");
		end
		$finish;
	end
endmodule

/* max_min_spacing_search.f */
rtl/mmss_pkg.sv
rtl/mmss_queue.sv
rtl/mmss_front.sv
rtl/mmss_back.sv
rtl/max_min_spacing_search.sv
bench/testbench.sv
